// File: rtl/blpg_pkg.sv
// Shared types and constants for the Bresenham line pixel generator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package blpg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int INC_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int COLOR_BITS  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [INC_BITS-1:0]   t_inc;
    typedef logic [COLOR_BITS-1:0] t_color;
    typedef logic signed [ERR_BITS-1:0] t_err;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic   mode;
        t_coord major_pos;
        t_coord major_end;
        t_coord minor_pos;
        t_coord span;
        t_inc   inc;
        logic   swapped;
        logic   down;
        t_color color;
    } t_item;

endpackage

// File: rtl/blpg_front.sv
// Front end: classifies an incoming item and works out line set-up.
// Depends on blpg_pkg.
module blpg_front (
    input  logic               i_mode,
    input  blpg_pkg::t_coord   i_start_x,
    input  blpg_pkg::t_coord   i_start_y,
    input  blpg_pkg::t_coord   i_end_x,
    input  blpg_pkg::t_coord   i_end_y,
    input  blpg_pkg::t_color   i_color,
    output blpg_pkg::t_item    o_item
);

    blpg_pkg::t_coord dx, dy;
    blpg_pkg::t_coord a_maj, a_min, b_maj, b_min;
    blpg_pkg::t_coord near_min, far_min, d_minor;
    logic             swapped, order;

    always_comb begin
        dx = (i_start_x > i_end_x) ? i_start_x - i_end_x : i_end_x - i_start_x;
        dy = (i_start_y > i_end_y) ? i_start_y - i_end_y : i_end_y - i_start_y;
        swapped = (dx < dy);

        a_maj = swapped ? i_start_y : i_start_x;
        a_min = swapped ? i_start_x : i_start_y;
        b_maj = swapped ? i_end_y   : i_end_x;
        b_min = swapped ? i_end_x   : i_end_y;

        // order endpoints so the major coordinate rises
        order    = (a_maj > b_maj);
        near_min = order ? b_min : a_min;
        far_min  = order ? a_min : b_min;
        d_minor  = swapped ? dx : dy;

        o_item.mode      = i_mode;
        o_item.major_pos = order ? b_maj : a_maj;
        o_item.major_end = order ? a_maj : b_maj;
        o_item.minor_pos = near_min;
        o_item.span      = swapped ? dy : dx;
        o_item.inc       = {d_minor, 1'b0};
        o_item.swapped   = swapped;
        o_item.down      = (near_min > far_min);
        o_item.color     = i_color;
    end

endmodule

// File: rtl/blpg_queue.sv
// Short queue of classified items between front and back.
// Depends on blpg_pkg.
module blpg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  blpg_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nonempty,
    output blpg_pkg::t_item  o_item
);

    blpg_pkg::t_item r_mem [blpg_pkg::QUEUE_DEPTH];
    logic [blpg_pkg::QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [blpg_pkg::QCNT_BITS-1:0] r_count;

    logic do_push, do_pop;

    assign o_full     = (r_count == blpg_pkg::QCNT_BITS'(blpg_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_item     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/blpg_back.sv
// Back end: holds the active line, steps the error term and emits pixels
// through an output register. Depends on blpg_pkg.
module blpg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  blpg_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output blpg_pkg::t_coord o_pixel_x,
    output blpg_pkg::t_coord o_pixel_y,
    output blpg_pkg::t_color o_pixel_color,
    output logic             o_last_pixel
);

    // line state
    logic             r_active;
    blpg_pkg::t_coord r_major_pos, r_major_end, r_minor_pos, r_span;
    blpg_pkg::t_inc   r_inc;
    blpg_pkg::t_err   r_err;
    logic             r_swapped, r_down;
    blpg_pkg::t_color r_color;

    // output register
    logic             r_out_valid;
    blpg_pkg::t_coord r_px, r_py;
    blpg_pkg::t_color r_out_color;
    logic             r_out_last;

    logic             can_take, start, emit, last, over;
    blpg_pkg::t_coord cur_pos, cur_end, cur_min, cur_span;
    blpg_pkg::t_inc   cur_inc;
    blpg_pkg::t_err   cur_err, sum, inc_ext, span_ext, two_span;
    logic             cur_swapped, cur_down;
    blpg_pkg::t_color cur_color;
    blpg_pkg::t_coord n_major_pos, n_minor_pos;
    blpg_pkg::t_err   n_err;

    assign can_take = !r_out_valid || !i_stall;
    assign o_pop    = i_item_valid && can_take;
    assign start    = (i_item.mode == blpg_pkg::MODE_START);
    // a step with no line in progress is dropped
    assign emit     = o_pop && (start || r_active);

    always_comb begin
        cur_pos     = start ? i_item.major_pos : r_major_pos;
        cur_end     = start ? i_item.major_end : r_major_end;
        cur_min     = start ? i_item.minor_pos : r_minor_pos;
        cur_span    = start ? i_item.span      : r_span;
        cur_inc     = start ? i_item.inc       : r_inc;
        cur_err     = start ? '0               : r_err;
        cur_swapped = start ? i_item.swapped   : r_swapped;
        cur_down    = start ? i_item.down      : r_down;
        cur_color   = start ? i_item.color     : r_color;

        last     = (cur_pos == cur_end);
        inc_ext  = $signed({{(blpg_pkg::ERR_BITS - blpg_pkg::INC_BITS){1'b0}}, cur_inc});
        span_ext = $signed({{(blpg_pkg::ERR_BITS - blpg_pkg::COORD_BITS){1'b0}}, cur_span});
        two_span = $signed({{(blpg_pkg::ERR_BITS - blpg_pkg::COORD_BITS - 1){1'b0}},
                            cur_span, 1'b0});
        sum      = cur_err + inc_ext;
        over     = (sum > span_ext);
        n_err    = over ? sum - two_span : sum;

        n_minor_pos = cur_min;
        if (over) begin
            n_minor_pos = cur_down ? cur_min - 1'b1 : cur_min + 1'b1;
        end
        n_major_pos = cur_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_active <= !last;
            end
            if (can_take) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_major_pos <= n_major_pos;
            r_major_end <= cur_end;
            r_minor_pos <= n_minor_pos;
            r_span      <= cur_span;
            r_inc       <= cur_inc;
            r_err       <= n_err;
            r_swapped   <= cur_swapped;
            r_down      <= cur_down;
            r_color     <= cur_color;

            r_px        <= cur_swapped ? cur_min : cur_pos;
            r_py        <= cur_swapped ? cur_pos : cur_min;
            r_out_color <= cur_color;
            r_out_last  <= last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule

// File: rtl/bresenham_line_pixel_generator_core.sv
// Bresenham line pixel generator, top level: front, queue and back end.
// Depends on blpg_pkg, blpg_front, blpg_queue and blpg_back.
//
// A mode 0 item starts a line between two endpoints and gives its first
// pixel; each mode 1 item gives the next pixel, the last one flagged with
// last_pixel. A mode 1 item with no line in progress gives nothing, and a
// mode 0 item during a line abandons it. Items are taken one per clock and
// pixels leave one per clock when nothing stalls: the error add, compare
// and coordinate step in the back end are combinational, and a two-entry
// queue between the set-up logic and the back end lets input and output
// stall independently. An input item is registered in the queue and then
// in the back end's output register before its pixel is valid.
module bresenham_line_pixel_generator_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_mode,
    input  blpg_pkg::t_coord i_start_x,
    input  blpg_pkg::t_coord i_start_y,
    input  blpg_pkg::t_coord i_end_x,
    input  blpg_pkg::t_coord i_end_y,
    input  blpg_pkg::t_color i_color,
    output logic             o_valid,
    input  logic             i_stall,
    output blpg_pkg::t_coord o_pixel_x,
    output blpg_pkg::t_coord o_pixel_y,
    output blpg_pkg::t_color o_pixel_color,
    output logic             o_last_pixel
);

    blpg_pkg::t_item front_item, head_item;
    logic            q_full, q_nonempty, q_pop;

    blpg_front u_front (
        .i_mode    (i_mode),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_color   (i_color),
        .o_item    (front_item)
    );

    blpg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid),
        .i_item     (front_item),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_item     (head_item)
    );

    blpg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (q_nonempty),
        .i_item        (head_item),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    assign o_stall = q_full;

endmodule
